>>> design/usq_pkg.sv
// Package for the uniform-step quadrature block: shared widths, codes,
// register reset values and the configuration struct.
// No dependencies.
package usq_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 48;
  localparam int RESULT_W   = 64;
  localparam int METHOD_W   = 2;
  localparam int COUNT_W    = 16;
  localparam int STEP_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Default parameter values
  localparam int DEF_COUNT_WIDTH      = 16;
  localparam int DEF_WEIGHT_FRAC_BITS = 24;
  localparam int QUEUE_DEPTH          = 2;

  // Method codes
  localparam logic [METHOD_W-1:0] METHOD_TRAP    = 2'd0;
  localparam logic [METHOD_W-1:0] METHOD_CUBIC   = 2'd1;
  localparam logic [METHOD_W-1:0] METHOD_FOUR    = 2'd2;
  localparam logic [METHOD_W-1:0] METHOD_SIMPSON = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_METHOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

  // Register reset values
  localparam logic [METHOD_W-1:0] RST_METHOD = METHOD_TRAP;
  localparam logic [COUNT_W-1:0]  RST_COUNT  = 16'd1;
  localparam logic [STEP_W-1:0]   RST_STEP   = 32'h0001_0000;

  // Configuration registers as seen by front and back
  typedef struct packed {
    logic [METHOD_W-1:0] method_select;
    logic [COUNT_W-1:0]  sample_count;
    logic [STEP_W-1:0]   step_width;
  } cfg_t;

endpackage

>>> design/usq_queue.sv
// Short register queue between the front and the back end.
// Depends on nothing; DEPTH must be at least 2.
module usq_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> design/usq_front.sv
// Front end: tracks the position in the run, picks the weight for each
// sample and flags the sample that closes the run. Depends on usq_pkg.
module usq_front #(
  parameter int COUNT_WIDTH      = usq_pkg::DEF_COUNT_WIDTH,
  parameter int WEIGHT_FRAC_BITS = usq_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  usq_pkg::cfg_t                         cfg,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  logic signed [usq_pkg::SAMPLE_W-1:0]   sample,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [usq_pkg::SAMPLE_W+WEIGHT_FRAC_BITS+1:0] push_data
);

  import usq_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int WW = F + 1;

  // Weights, rounded to nearest, Q1.F
  localparam longint unsigned ONE2 = 64'd1 << (F + 1);
  localparam longint unsigned W_1_2   = (ONE2 + 2) / 4;
  localparam longint unsigned W_5_12  = (5 * ONE2 + 12) / 24;
  localparam longint unsigned W_13_12 = (13 * ONE2 + 12) / 24;
  localparam longint unsigned W_3_8   = (3 * ONE2 + 8) / 16;
  localparam longint unsigned W_7_6   = (7 * ONE2 + 6) / 12;
  localparam longint unsigned W_23_24 = (23 * ONE2 + 24) / 48;
  localparam longint unsigned W_1_3   = (ONE2 + 3) / 6;
  localparam longint unsigned W_4_3   = (4 * ONE2 + 3) / 6;
  localparam longint unsigned W_2_3   = (2 * ONE2 + 3) / 6;
  localparam longint unsigned W_UNIT  = 64'd1 << F;

  logic [CW-1:0] position;
  logic [CW-1:0] n_raw;
  logic [CW-1:0] n;
  logic [CW-1:0] i_eff;
  logic [1:0]    k;
  logic [CW:0]   i_plus_k;
  logic          in_middle;
  logic [CW-1:0] two_k;
  logic [CW-1:0] top;
  logic [CW-1:0] idx_w;
  logic [1:0]    head_idx;
  logic [WW-1:0] weight;
  logic          is_last;
  logic          accept;

  assign sample_ready = push_ready;
  assign push_valid   = sample_valid;
  assign accept       = sample_valid && push_ready;

  // Run length and effective position
  always_comb begin
    n_raw   = CW'(cfg.sample_count);
    n       = (n_raw == '0) ? CW'(1) : n_raw;
    i_eff   = (position >= n) ? n - 1'b1 : position;
    is_last = (i_eff == n - 1'b1);
  end

  // Head length per method
  always_comb begin
    case (cfg.method_select)
      METHOD_TRAP:    k = 2'd1;
      METHOD_CUBIC:   k = 2'd2;
      METHOD_FOUR:    k = 2'd3;
      METHOD_SIMPSON: k = 2'd1;
      default:        k = 2'd1;
    endcase
  end

  // Head index: leading edge, or the mirrored tail with the overlap clamp
  always_comb begin
    i_plus_k  = {1'b0, i_eff} + (CW + 1)'(k);
    in_middle = (i_plus_k < {1'b0, n});
    two_k     = CW'({k, 1'b0});
    top       = (n > two_k) ? n : two_k;
    idx_w     = top - 1'b1 - i_eff;
    if (i_eff < CW'(k)) begin
      head_idx = i_eff[1:0];
    end else if (idx_w >= CW'(k)) begin
      head_idx = k - 1'b1;
    end else begin
      head_idx = idx_w[1:0];
    end
  end

  // Weight select
  always_comb begin
    if (in_middle && !(i_eff < CW'(k))) begin
      if (cfg.method_select == METHOD_SIMPSON) begin
        weight = i_eff[0] ? WW'(W_4_3) : WW'(W_2_3);
      end else begin
        weight = WW'(W_UNIT);
      end
    end else begin
      case (cfg.method_select)
        METHOD_TRAP:  weight = WW'(W_1_2);
        METHOD_CUBIC: weight = (head_idx == 2'd0) ? WW'(W_5_12) : WW'(W_13_12);
        METHOD_FOUR: begin
          case (head_idx)
            2'd0:    weight = WW'(W_3_8);
            2'd1:    weight = WW'(W_7_6);
            default: weight = WW'(W_23_24);
          endcase
        end
        default:      weight = WW'(W_1_3);
      endcase
    end
  end

  assign push_data = {sample, weight, is_last};

  // Position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= is_last ? '0 : i_eff + 1'b1;
    end
  end

endmodule

>>> design/usq_back.sv
// Back end: weighted product, rounding, saturating accumulation, and the
// multi-cycle scaling of a closed run by the step width. Depends on usq_pkg.
module usq_back #(
  parameter int WEIGHT_FRAC_BITS = usq_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  usq_pkg::cfg_t                         cfg,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  logic [usq_pkg::SAMPLE_W+WEIGHT_FRAC_BITS+1:0] pop_data,
  output logic                                  integral_valid,
  input  logic                                  integral_ready,
  output logic signed [usq_pkg::RESULT_W-1:0]   integral
);

  import usq_pkg::*;

  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int WW = F + 1;
  localparam int PW = SAMPLE_W + WW + 1;
  localparam int RW = PW - F;

  // Scaler states
  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_ADD  = 2'd2;

  logic signed [SAMPLE_W-1:0] in_sample;
  logic [WW-1:0]              in_weight;
  logic                       in_last;

  logic                       valid1;
  logic                       last1;
  logic signed [PW-1:0]       prod1;
  logic                       consume1;
  logic                       busy;

  logic [PW-1:0]              prod_rnd;
  logic signed [RW-1:0]       rp;
  logic signed [SUM_W+1:0]    acc_wide;
  logic signed [SUM_W-1:0]    sum_sat;
  logic signed [SUM_W-1:0]    running_sum;

  logic [1:0]                 sc_state;
  logic signed [SUM_W-1:0]    sc_sum;
  logic signed [RESULT_W:0]   p_hi;
  logic [SUM_W-1:0]           p_lo;
  logic [SUM_W-1:0]           p_lo_rnd;

  assign {in_sample, in_weight, in_last} = pop_data;

  // Stage handshake: a closing item waits for a free scaler
  assign busy      = (sc_state != SC_IDLE) || integral_valid;
  assign consume1  = valid1 && !(last1 && busy);
  assign pop_ready = !valid1 || consume1;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      prod1 <= in_sample * $signed({1'b0, in_weight});
      last1 <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (pop_ready) begin
      valid1 <= pop_valid;
    end
  end

  // Round to Q.16 and accumulate with saturation
  always_comb begin
    prod_rnd = prod1 + PW'(64'd1 << (F - 1));
    rp       = prod_rnd[PW-1:F];
    acc_wide = (SUM_W + 2)'(running_sum) + (SUM_W + 2)'(rp);
    if (acc_wide[SUM_W+1:SUM_W-1] == 3'b000 || acc_wide[SUM_W+1:SUM_W-1] == 3'b111) begin
      sum_sat = acc_wide[SUM_W-1:0];
    end else if (!acc_wide[SUM_W+1]) begin
      sum_sat = {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sum_sat = {1'b1, {(SUM_W - 1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (consume1) begin
      running_sum <= last1 ? '0 : sum_sat;
    end
  end

  // Scaler: sum*h as signed high part times h plus rounded low part times h
  always_ff @(posedge clk) begin
    if (consume1 && last1) begin
      sc_sum <= sum_sat;
    end
    if (sc_state == SC_MUL) begin
      p_hi <= $signed(sc_sum[SUM_W-1:16]) * $signed({1'b0, cfg.step_width});
      p_lo <= SUM_W'(sc_sum[15:0]) * SUM_W'(cfg.step_width);
    end
  end

  assign p_lo_rnd = p_lo + SUM_W'(16'h8000);

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_state <= SC_IDLE;
    end else begin
      case (sc_state)
        SC_IDLE: if (consume1 && last1) begin
          sc_state <= SC_MUL;
        end
        SC_MUL:  sc_state <= SC_ADD;
        SC_ADD:  sc_state <= SC_IDLE;
        default: sc_state <= SC_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (sc_state == SC_ADD) begin
      integral <= p_hi[RESULT_W-1:0] + RESULT_W'(p_lo_rnd[SUM_W-1:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_valid <= 1'b0;
    end else if (sc_state == SC_ADD) begin
      integral_valid <= 1'b1;
    end else if (integral_ready) begin
      integral_valid <= 1'b0;
    end
  end

endmodule

>>> design/uniform_step_quadrature.sv
// Uniform-step quadrature: top level with configuration registers, front
// end, item queue and back end. Depends on usq_pkg, usq_front, usq_queue, usq_back.
//
// Each accepted sample is weighted by the configured rule (trapezoid, cubic,
// four-point or Simpson end corrections) and added into a saturating 48-bit
// sum; the sample that closes a run of sample_count samples produces one
// integral = sum * step_width in Q48.16. Samples are taken at one per cycle
// while the back end keeps up; the back end multiplies in one stage and
// accumulates in the next. A closing sample needs the result scaler, which
// forms two partial products in SC_MUL, then adds them into the output
// register in SC_ADD, and stays held until its result is taken, so runs of
// fewer than about four samples, or a slow result consumer, lower the rate.
// A result passes the queue, the multiply stage and the scaler. Configuration
// must be written only while the block holds no work; this is not enforced.
module uniform_step_quadrature #(
  parameter int COUNT_WIDTH      = usq_pkg::DEF_COUNT_WIDTH,
  parameter int WEIGHT_FRAC_BITS = usq_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [usq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [usq_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic signed [usq_pkg::SAMPLE_W-1:0]  sample,
  output logic                                 integral_valid,
  input  logic                                 integral_ready,
  output logic signed [usq_pkg::RESULT_W-1:0]  integral
);

  import usq_pkg::*;

  localparam int QW = SAMPLE_W + WEIGHT_FRAC_BITS + 2;

  cfg_t          cfg;
  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.method_select <= RST_METHOD;
      cfg.sample_count  <= RST_COUNT;
      cfg.step_width    <= RST_STEP;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_METHOD: cfg.method_select <= cfg_data[METHOD_W-1:0];
        REG_COUNT:  cfg.sample_count  <= cfg_data[COUNT_W-1:0];
        REG_STEP:   cfg.step_width    <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  usq_front #(
    .COUNT_WIDTH      (COUNT_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  usq_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  usq_back #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .integral_valid (integral_valid),
    .integral_ready (integral_ready),
    .integral       (integral)
  );

endmodule

>>> design/usq_checker.sv
// Port-level checks for the uniform-step quadrature block, and the bind
// that attaches them to the top level. Depends on usq_pkg.
module usq_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 cfg_write,
  input logic [usq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input logic                                 sample_valid,
  input logic                                 sample_ready,
  input logic                                 integral_valid,
  input logic                                 integral_ready,
  input logic signed [usq_pkg::RESULT_W-1:0]  integral
);

  import usq_pkg::*;

  logic seen_item;

  // Set once any sample item has been accepted since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_item <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      seen_item <= 1'b1;
    end
  end

  // A stalled result holds its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    integral_valid && !integral_ready |=> integral_valid && $stable(integral))
    else $error("result changed or dropped while stalled");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !integral_valid)
    else $error("result valid right after reset");

  // No result without an accepted sample item
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(integral_valid) |-> seen_item)
    else $error("result without any accepted sample");

  // Configuration writes carry a known index
  a_cfg_known: assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> !$isunknown(cfg_index))
    else $error("configuration write with unknown index");

endmodule

bind uniform_step_quadrature usq_checker u_usq_checker (.*);

>>> tb/sv/tb_uniform_step_quadrature.sv
// Testbench for uniform_step_quadrature: streams samples over a randomized valid/ready
// handshake and checks every integral against an in-bench weighted-sum predictor.
// Depends on usq_pkg and the uniform_step_quadrature RTL.
`timescale 1ns / 100ps

module tb_uniform_step_quadrature;
  import usq_pkg::*;

  localparam int FRAC_BITS    = DEF_WEIGHT_FRAC_BITS;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic [CFG_IDX_W-1:0]       REG_UNUSED = 2'd3;
  localparam logic [STEP_W-1:0]          STEP_ONE   = 32'h0001_0000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  logic                        clk            = 1'b0;
  logic                        rst            = 1'b1;
  logic                        cfg_write      = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index      = '0;
  logic [CFG_DATA_W-1:0]       cfg_data       = '0;
  logic                        sample_valid   = 1'b0;
  logic                        sample_ready;
  logic signed [SAMPLE_W-1:0]  sample         = '0;
  logic                        integral_valid;
  logic                        integral_ready = 1'b0;
  logic signed [RESULT_W-1:0]  integral;

  // Predictor state: register copy, run position and weighted sum
  cfg_t               model_cfg;
  logic [COUNT_W-1:0] run_pos;
  longint             run_sum;

  logic signed [SAMPLE_W-1:0] pending_samples[$];
  logic signed [RESULT_W-1:0] integral_expected[$];

  int send_idle_pct  = 0;
  int take_idle_pct  = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  uniform_step_quadrature dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .integral_valid (integral_valid),
    .integral_ready (integral_ready),
    .integral       (integral)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Constant num/den in Q1.FRAC_BITS, rounded to nearest, ties up
  function automatic longint q_weight(longint num, longint den);
    return ((num <<< (FRAC_BITS + 1)) + den) / (2 * den);
  endfunction

  function automatic int head_length(logic [METHOD_W-1:0] m);
    case (m)
      METHOD_CUBIC: return 2;
      METHOD_FOUR:  return 3;
      default:      return 1;
    endcase
  endfunction

  function automatic longint head_weight(logic [METHOD_W-1:0] m, int idx);
    case (m)
      METHOD_TRAP:  return q_weight(1, 2);
      METHOD_CUBIC: return (idx == 0) ? q_weight(5, 12) : q_weight(13, 12);
      METHOD_FOUR: begin
        if (idx == 0) return q_weight(3, 8);
        if (idx == 1) return q_weight(7, 6);
        return q_weight(23, 24);
      end
      default:      return q_weight(1, 3);
    endcase
  endfunction

  // Head weights at the start, interior weights, mirrored head at the tail
  function automatic longint sample_weight(logic [METHOD_W-1:0] m, int i, int n);
    int k;
    int idx;
    k = head_length(m);
    if (i < k) begin
      idx = i;
    end else if (n >= k && i < n - k) begin
      if (m == METHOD_SIMPSON) return i[0] ? q_weight(4, 3) : q_weight(2, 3);
      return longint'(1) <<< FRAC_BITS;
    end else begin
      idx = ((n > 2 * k) ? n : 2 * k) - 1 - i;
    end
    if (idx >= k) idx = k - 1;
    return head_weight(m, idx);
  endfunction

  // floor((sum * h + half) / 2^16), computed wide enough to be exact
  function automatic logic signed [RESULT_W-1:0] scale_by_step(longint acc,
                                                               logic [STEP_W-1:0] h);
    logic signed [95:0] wide;
    wide = acc;
    wide = wide * $signed({64'd0, h});
    wide = (wide + 96'sd32768) >>> 16;
    return wide[RESULT_W-1:0];
  endfunction

  // Fold one accepted sample into the run; a closing sample yields an integral
  task automatic integrate_sample(logic signed [SAMPLE_W-1:0] y);
    int     n;
    int     i;
    longint acc;
    n = (model_cfg.sample_count == 0) ? 1 : int'(model_cfg.sample_count);
    i = (run_pos >= n) ? n - 1 : int'(run_pos);
    acc = longint'(y) * sample_weight(model_cfg.method_select, i, n);
    acc = run_sum + ((acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    if (i == n - 1) begin
      integral_expected.push_back(scale_by_step(acc, model_cfg.step_width));
      run_pos = '0;
      run_sum = 0;
    end else begin
      run_sum = acc;
      run_pos = COUNT_W'(i + 1);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_METHOD: model_cfg.method_select = data[METHOD_W-1:0];
      REG_COUNT:  model_cfg.sample_count  = data[COUNT_W-1:0];
      REG_STEP:   model_cfg.step_width    = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every item is taken and every integral is back, then let the
  // pipeline empty out (a partial run leaves work with no result pending)
  task automatic settle();
    while (pending_samples.size() != 0 || integral_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  // Sample driver: the head of the queue stays on the bus until accepted
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        integrate_sample(sample);
        void'(pending_samples.pop_front());
      end
      if (!sample_valid || sample_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_valid <= 1'b1;
          sample       <= pending_samples[0];
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Integral monitor with random back-pressure
  always @(posedge clk) begin : integral_check
    logic signed [RESULT_W-1:0] want;
    if (rst) begin
      integral_ready <= 1'b0;
    end else begin
      if (integral_valid && integral_ready) begin
        if (integral_expected.size() == 0) begin
          report_mismatch($sformatf("integral %h with none expected", integral));
        end else begin
          want = integral_expected.pop_front();
          if (integral !== want)
            report_mismatch($sformatf("integral mismatch: expected %h got %h", want, integral));
        end
      end
      integral_ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] junk;
    int n;
    int burst_len;
    int fed;
    model_cfg = '{RST_METHOD, RST_COUNT, RST_STEP};
    run_pos   = '0;
    run_sum   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset setup: trapezoid, one-sample runs, unit step
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(-32'sd1);
    settle();

    // Zero count behaves as one; largest step
    write_reg(REG_COUNT, 32'hFFFF_0000);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    settle();

    // Cubic, run shorter than two heads: tail overlaps the head
    write_reg(REG_METHOD, CFG_DATA_W'(METHOD_CUBIC));
    write_reg(REG_COUNT, 32'd3);
    write_reg(REG_STEP, 32'h0000_8000);
    repeat (3) pending_samples.push_back(SAMPLE_MAX);
    settle();

    // Four-point with fewer samples than its head; junk in the upper bits
    write_reg(REG_METHOD, {30'h3FFF_FFFF, METHOD_FOUR});
    write_reg(REG_COUNT, 32'd2);
    repeat (2) pending_samples.push_back(SAMPLE_MIN);
    settle();

    // Four-point with a single interior sample
    write_reg(REG_COUNT, 32'd7);
    repeat (7) pending_samples.push_back($urandom);
    settle();

    // Simpson alternating interior weights, zero step
    write_reg(REG_METHOD, CFG_DATA_W'(METHOD_SIMPSON));
    write_reg(REG_COUNT, 32'd4);
    write_reg(REG_STEP, '0);
    repeat (4) pending_samples.push_back($urandom);
    settle();

    // Unused index is ignored; a maximum-length run cut short by a smaller count
    write_reg(REG_UNUSED, $urandom);
    write_reg(REG_METHOD, CFG_DATA_W'(METHOD_TRAP));
    write_reg(REG_COUNT, 32'h0000_FFFF);
    write_reg(REG_STEP, STEP_ONE);
    repeat (5) pending_samples.push_back($urandom);
    settle();
    write_reg(REG_COUNT, 32'hABCD_0003);
    pending_samples.push_back($urandom);
    settle();

    // Random runs under three idling profiles
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 80 : 0;
      take_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 21 : 0;
      fed = 0;
      while (fed < RANDOM_ITEMS / 3) begin
        settle();
        junk = $urandom;
        write_reg(REG_METHOD, {junk[31:2], 2'($urandom_range(0, 3))});
        case ($urandom_range(0, 9))
          0:       n = 0;
          1:       n = $urandom_range(41, 65535);
          2, 3:    n = $urandom_range(9, 40);
          default: n = $urandom_range(1, 8);
        endcase
        junk = $urandom;
        write_reg(REG_COUNT, {junk[31:16], 16'(n)});
        case ($urandom_range(0, 5))
          0:       write_reg(REG_STEP, '0);
          1:       write_reg(REG_STEP, '1);
          2:       write_reg(REG_STEP, $urandom);
          default: write_reg(REG_STEP, $urandom_range(32'h0000_4000, 32'h0004_0000));
        endcase
        if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);

        // Mostly whole runs; long counts and some bursts leave a run open
        if (n == 0) n = 1;
        if (n > 40) begin
          burst_len = $urandom_range(1, 30);
        end else begin
          burst_len = n * $urandom_range(1, 5);
          if (n > 1 && $urandom_range(0, 3) == 0) burst_len += $urandom_range(1, n - 1);
        end
        repeat (burst_len) begin
          case ($urandom_range(0, 9))
            0:       pending_samples.push_back(SAMPLE_MAX);
            1:       pending_samples.push_back(SAMPLE_MIN);
            2:       pending_samples.push_back($urandom_range(0, 32'h3_FFFF) - 32'h2_0000);
            default: pending_samples.push_back($urandom);
          endcase
        end
        fed += burst_len;
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
